// File: hw/rtl/rdx_pkg.sv
// Shared types and codes for the DMA expansion RAM controller.
// No dependencies.
package rdx_pkg;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TRIG  = 2'd2;
	localparam logic [1:0] CMD_DONE  = 2'd3;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_REG  = 2'd1;
	localparam logic [1:0] KIND_HRD  = 2'd2;
	localparam logic [1:0] KIND_HWR  = 2'd3;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_READ  = 2'd1;
	localparam logic [1:0] PH_WRITE = 2'd2;

	localparam logic [1:0] MODE_TO_RAM  = 2'd0;
	localparam logic [1:0] MODE_TO_HOST = 2'd1;
	localparam logic [1:0] MODE_SWAP    = 2'd2;
	localparam logic [1:0] MODE_COMPARE = 2'd3;

	localparam logic [3:0] REG_STATUS = 4'd0;
	localparam logic [3:0] REG_CMD    = 4'd1;
	localparam logic [3:0] REG_HLO    = 4'd2;
	localparam logic [3:0] REG_HHI    = 4'd3;
	localparam logic [3:0] REG_E0     = 4'd4;
	localparam logic [3:0] REG_E1     = 4'd5;
	localparam logic [3:0] REG_E2     = 4'd6;
	localparam logic [3:0] REG_LLO    = 4'd7;
	localparam logic [3:0] REG_LHI    = 4'd8;
	localparam logic [3:0] REG_IMASK  = 4'd9;
	localparam logic [3:0] REG_ACTL   = 4'd10;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] bus_data;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  read_data;
		logic [15:0] bus_address;
		logic [7:0]  bus_write_data;
		logic        busy;
	} result_t;

	typedef struct packed {
		logic clearing;
		logic out_full;
	} back_stat_t;

endpackage

// File: hw/rtl/dma_ram_expansion_controller_unit.sv
// DMA controller with expansion RAM. Front queue of 2 items, back engine, 2-deep result queue.
// The back engine takes one item at a time from the front queue: RAM read, then execute;
// a RAM-to-host request step adds a fetch and an issue state for the extra RAM read at the
// new address. The front queue keeps accepting items while it is not full.
// Reset: asynchronous, active low; afterwards a sweep zeroes all 2**RAM_ADDR_BITS RAM words
// while full stays high. Depends on rdx_pkg, rdx_front, rdx_back, rdx_fifo.
module dma_ram_expansion_controller_unit #(
	parameter int RAM_ADDR_BITS = 19
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [3:0]  reg_index,
	input  logic [7:0]  write_data,
	input  logic [7:0]  bus_data,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  read_data,
	output logic [15:0] bus_address,
	output logic [7:0]  bus_write_data,
	output logic        transfer_busy,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);
	rdx_pkg::item_t      item;
	logic                item_empty, item_pop, out_full, res_push;
	rdx_pkg::result_t    res_in, res_rd;
	rdx_pkg::back_stat_t bstat;
	logic [$bits(rdx_pkg::result_t)-1:0] out_rd;

	rdx_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.command(command), .reg_index(reg_index), .write_data(write_data),
		.bus_data(bus_data), .bstat(bstat), .item_pop(item_pop),
		.item(item), .item_empty(item_empty)
	);

	rdx_back #(.RAM_ADDR_BITS(RAM_ADDR_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.item(item), .item_empty(item_empty), .item_pop(item_pop),
		.out_full(out_full), .res_push(res_push), .res_out(res_in), .bstat(bstat)
	);

	rdx_fifo #(.W($bits(rdx_pkg::result_t)), .DEPTH(2)) u_outq (
		.clk(clk), .arst_n(arst_n),
		.wr_en(res_push), .wr_data(res_in), .full(out_full),
		.rd_en(pop), .rd_data(out_rd), .empty(empty)
	);

	assign res_rd         = rdx_pkg::result_t'(out_rd);
	assign kind           = res_rd.kind;
	assign read_data      = res_rd.read_data;
	assign bus_address    = res_rd.bus_address;
	assign bus_write_data = res_rd.bus_write_data;
	assign transfer_busy  = res_rd.busy;
endmodule

// File: hw/rtl/rdx_fifo.sv
// Small register queue used between the front, the back and the result side.
// No package dependencies.
module rdx_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end
endmodule

// File: hw/rtl/rdx_front.sv
// Front end: takes transactions, zeroes unused payload and queues them for the back end.
// Depends on rdx_pkg and rdx_fifo.
module rdx_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         command,
	input  logic [3:0]         reg_index,
	input  logic [7:0]         write_data,
	input  logic [7:0]         bus_data,
	input  rdx_pkg::back_stat_t bstat,
	input  logic               item_pop,
	output rdx_pkg::item_t     item,
	output logic               item_empty
);
	rdx_pkg::item_t in_item;
	logic           q_full;
	logic [$bits(rdx_pkg::item_t)-1:0] q_rd;

	// drop payload bits that the operation never looks at
	always_comb begin
		in_item.op         = command;
		in_item.reg_index  = (command == rdx_pkg::CMD_DONE || command == rdx_pkg::CMD_TRIG)
			? 4'd0 : reg_index;
		in_item.write_data = (command == rdx_pkg::CMD_WRITE) ? write_data : 8'd0;
		in_item.bus_data   = (command == rdx_pkg::CMD_DONE) ? bus_data : 8'd0;
	end

	assign full = q_full | bstat.clearing;
	assign item = rdx_pkg::item_t'(q_rd);

	rdx_fifo #(.W($bits(rdx_pkg::item_t)), .DEPTH(2)) u_q (
		.clk(clk), .arst_n(arst_n),
		.wr_en(push & ~full), .wr_data(in_item), .full(q_full),
		.rd_en(item_pop), .rd_data(q_rd), .empty(item_empty)
	);
endmodule

// File: hw/rtl/rdx_back.sv
// Back end: register file, transfer engine and expansion RAM with its clearing sweep.
// Depends on rdx_pkg.
module rdx_back #(
	parameter int RAM_ADDR_BITS = 19
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata,
	input  rdx_pkg::item_t      item,
	input  logic                item_empty,
	output logic                item_pop,
	input  logic                out_full,
	output logic                res_push,
	output rdx_pkg::result_t    res_out,
	output rdx_pkg::back_stat_t bstat
);
	localparam int N = RAM_ADDR_BITS;
	localparam logic [2:0] SQ_CLEAR = 3'd0;
	localparam logic [2:0] SQ_IDLE  = 3'd1;
	localparam logic [2:0] SQ_EXEC  = 3'd2;
	localparam logic [2:0] SQ_FETCH = 3'd3;
	localparam logic [2:0] SQ_ISSUE = 3'd4;

	logic [2:0]  sq_q;
	logic [N-1:0] clr_q;
	logic [7:0]  ram_q [2**N];
	logic [7:0]  rdata_q;
	rdx_pkg::item_t   itm_q;
	rdx_pkg::result_t res_q;

	logic [1:0]  size_q;
	logic [7:0]  status_q, cmd_q, imask_q, actl_q;
	logic [15:0] hbase_q, len_q, chost_q;
	logic [23:0] ebase_q, cexp_q;
	logic [16:0] rem_q;
	logic [1:0]  phase_q;

	logic [7:0]  n_status, n_cmd, n_imask, n_actl;
	logic [15:0] n_hbase, n_len, n_chost;
	logic [23:0] n_ebase, n_cexp;
	logic [16:0] n_rem;
	logic [1:0]  n_phase;
	rdx_pkg::result_t res;
	logic        do_start, do_adv, do_fin, do_iss, need_fetch, busy;
	logic        ram_we;
	logic [7:0]  ram_wd;
	logic [23:0] m24;
	logic [N-1:0] idx;

	always_comb begin
		case (size_q)
			2'd0:    m24 = 24'h01FFFF;
			2'd1:    m24 = 24'h03FFFF;
			default: m24 = 24'h07FFFF;
		endcase
	end
	assign idx = cexp_q[N-1:0] & m24[N-1:0];

	assign bstat.clearing = (sq_q == SQ_CLEAR);
	assign bstat.out_full = out_full;
	assign item_pop = (sq_q == SQ_IDLE) & ~item_empty & ~out_full;
	assign busy = (phase_q != rdx_pkg::PH_IDLE);

	always_comb begin
		n_status = status_q; n_cmd = cmd_q; n_imask = imask_q; n_actl = actl_q;
		n_hbase = hbase_q; n_len = len_q; n_chost = chost_q;
		n_ebase = ebase_q; n_cexp = cexp_q; n_rem = rem_q; n_phase = phase_q;
		res = '0;
		res.busy = busy;
		do_start = 1'b0; do_adv = 1'b0; do_fin = 1'b0; do_iss = 1'b0;
		need_fetch = 1'b0; ram_we = 1'b0; ram_wd = itm_q.bus_data;
		case (itm_q.op)
			rdx_pkg::CMD_READ: begin
				res.kind = rdx_pkg::KIND_REG;
				case (itm_q.reg_index)
					rdx_pkg::REG_STATUS: begin
						res.read_data = status_q;
						n_status = status_q & 8'h1F;
					end
					rdx_pkg::REG_CMD:   res.read_data = cmd_q;
					rdx_pkg::REG_HLO:   res.read_data = hbase_q[7:0];
					rdx_pkg::REG_HHI:   res.read_data = hbase_q[15:8];
					rdx_pkg::REG_E0:    res.read_data = ebase_q[7:0];
					rdx_pkg::REG_E1:    res.read_data = ebase_q[15:8];
					rdx_pkg::REG_E2:    res.read_data = ebase_q[23:16] | 8'hF8;
					rdx_pkg::REG_LLO:   res.read_data = len_q[7:0];
					rdx_pkg::REG_LHI:   res.read_data = len_q[15:8];
					rdx_pkg::REG_IMASK: res.read_data = imask_q | 8'h1F;
					rdx_pkg::REG_ACTL:  res.read_data = actl_q | 8'h3F;
					default:            res.read_data = 8'hFF;
				endcase
			end
			rdx_pkg::CMD_WRITE: begin
				if (!busy) begin
					case (itm_q.reg_index)
						rdx_pkg::REG_CMD: begin
							n_cmd = itm_q.write_data;
							do_start = ((itm_q.write_data & 8'h90) == 8'h90);
						end
						rdx_pkg::REG_HLO:   n_hbase[7:0]   = itm_q.write_data;
						rdx_pkg::REG_HHI:   n_hbase[15:8]  = itm_q.write_data;
						rdx_pkg::REG_E0:    n_ebase[7:0]   = itm_q.write_data;
						rdx_pkg::REG_E1:    n_ebase[15:8]  = itm_q.write_data;
						rdx_pkg::REG_E2:    n_ebase[23:16] = itm_q.write_data;
						rdx_pkg::REG_LLO:   n_len[7:0]     = itm_q.write_data;
						rdx_pkg::REG_LHI:   n_len[15:8]    = itm_q.write_data;
						rdx_pkg::REG_IMASK: n_imask        = itm_q.write_data;
						rdx_pkg::REG_ACTL:  n_actl         = itm_q.write_data;
						default: ;
					endcase
				end
			end
			rdx_pkg::CMD_TRIG: begin
				do_start = !busy && ((cmd_q & 8'h90) == 8'h80);
			end
			default: begin
				if (busy) begin
					if (phase_q == rdx_pkg::PH_WRITE) begin
						do_adv = 1'b1;
					end else if (cmd_q[1:0] == rdx_pkg::MODE_TO_RAM) begin
						ram_we = 1'b1;
						do_adv = 1'b1;
					end else if (cmd_q[1:0] == rdx_pkg::MODE_SWAP) begin
						res.kind = rdx_pkg::KIND_HWR;
						res.bus_address = chost_q;
						res.bus_write_data = rdata_q;
						res.busy = 1'b1;
						ram_we = 1'b1;
						n_phase = rdx_pkg::PH_WRITE;
					end else if (rdata_q != itm_q.bus_data) begin
						n_status = n_status | 8'h20;
						do_fin = 1'b1;
					end else begin
						do_adv = 1'b1;
					end
				end
			end
		endcase
		if (do_start) begin
			n_chost = hbase_q;
			n_cexp = ebase_q;
			n_rem = (len_q != 16'd0) ? {1'b0, len_q} : 17'h10000;
			do_iss = 1'b1;
		end
		if (do_adv) begin
			n_rem = rem_q - 17'd1;
			if (!actl_q[7]) n_chost = chost_q + 16'd1;
			if (!actl_q[6]) n_cexp = cexp_q + 24'd1;
			if (n_rem == 17'd0) do_fin = 1'b1;
			else do_iss = 1'b1;
		end
		if (do_fin) begin
			if (!n_cmd[5]) begin
				n_hbase = n_chost;
				n_ebase = n_cexp;
				n_len = n_rem[15:0];
			end
			n_status = n_status | 8'h40;
			n_cmd = n_cmd & 8'h7F;
			n_phase = rdx_pkg::PH_IDLE;
			res.kind = rdx_pkg::KIND_NONE;
			res.busy = 1'b0;
		end
		if (do_iss) begin
			res.bus_address = n_chost;
			res.busy = 1'b1;
			if (n_cmd[1:0] == rdx_pkg::MODE_TO_HOST) begin
				res.kind = rdx_pkg::KIND_HWR;
				n_phase = rdx_pkg::PH_WRITE;
				need_fetch = 1'b1;
			end else begin
				res.kind = rdx_pkg::KIND_HRD;
				n_phase = rdx_pkg::PH_READ;
			end
		end
	end

	always_comb begin
		res_push = 1'b0;
		res_out = res;
		if (sq_q == SQ_EXEC) begin
			res_push = ~need_fetch;
		end else if (sq_q == SQ_ISSUE) begin
			res_push = 1'b1;
			res_out = res_q;
			res_out.bus_write_data = rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q <= SQ_CLEAR;
			clr_q <= '0;
			size_q <= 2'd0;
			status_q <= 8'h40;
			cmd_q <= '0; imask_q <= '0; actl_q <= '0;
			hbase_q <= '0; len_q <= '0; chost_q <= '0;
			ebase_q <= '0; cexp_q <= '0; rem_q <= '0;
			phase_q <= rdx_pkg::PH_IDLE;
		end else begin
			case (sq_q)
				SQ_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) sq_q <= SQ_IDLE;
				end
				SQ_IDLE: if (item_pop) sq_q <= SQ_EXEC;
				SQ_EXEC: begin
					status_q <= n_status; cmd_q <= n_cmd; imask_q <= n_imask;
					actl_q <= n_actl; hbase_q <= n_hbase; len_q <= n_len;
					chost_q <= n_chost; ebase_q <= n_ebase; cexp_q <= n_cexp;
					rem_q <= n_rem; phase_q <= n_phase;
					sq_q <= need_fetch ? SQ_FETCH : SQ_IDLE;
				end
				SQ_FETCH: sq_q <= SQ_ISSUE;
				SQ_ISSUE: sq_q <= SQ_IDLE;
				default: sq_q <= SQ_IDLE;
			endcase
			if (cfg_we) begin
				size_q <= cfg_wdata;
				status_q[4] <= (cfg_wdata != 2'd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) itm_q <= item;
		if (sq_q == SQ_EXEC) res_q <= res;
	end

	// one port: write during the sweep or a transfer step, otherwise read at the index
	always_ff @(posedge clk) begin
		if (sq_q == SQ_CLEAR) begin
			ram_q[clr_q] <= 8'd0;
		end else if (sq_q == SQ_EXEC && ram_we) begin
			ram_q[idx] <= ram_wd;
		end else begin
			rdata_q <= ram_q[idx];
		end
	end
endmodule

// File: hw/rtl/rdx_checker.sv
// Port-level checks for the DMA expansion controller, bound to the top level.
// Depends on rdx_pkg.
module rdx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [1:0]  command,
	input logic [3:0]  reg_index,
	input logic [7:0]  write_data,
	input logic [7:0]  bus_data,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  kind,
	input logic [7:0]  read_data,
	input logic [15:0] bus_address,
	input logic [7:0]  bus_write_data,
	input logic        transfer_busy,
	input logic        cfg_we,
	input logic [1:0]  cfg_wdata
);
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind != rdx_pkg::KIND_REG |-> read_data == 8'd0)
		else $error("read_data set on a non-read transaction");

	a_wd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind != rdx_pkg::KIND_HWR |-> bus_write_data == 8'd0)
		else $error("bus_write_data set on a non-write transaction");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind == rdx_pkg::KIND_NONE || kind == rdx_pkg::KIND_REG)
		|-> bus_address == 16'd0)
		else $error("bus_address set without a bus request");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind == rdx_pkg::KIND_HRD || kind == rdx_pkg::KIND_HWR)
		|-> transfer_busy)
		else $error("bus request without transfer_busy");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(kind) && $stable(bus_address))
		else $error("waiting result changed");
endmodule

bind dma_ram_expansion_controller_unit rdx_checker u_rdx_checker (.*);

// File: sim/dma_ram_expansion_controller_unit_chk.sv
// Checker for the DMA expansion RAM controller: predicts each result from the accepted items
// and compares it field by field with the popped results. Depends on rdx_pkg.
`timescale 1ns / 100ps
module dma_ram_expansion_controller_unit_chk (
	input  logic        clk,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  command,
	input  logic [3:0]  reg_index,
	input  logic [7:0]  write_data,
	input  logic [7:0]  bus_data,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  kind,
	input  logic [7:0]  read_data,
	input  logic [15:0] bus_address,
	input  logic [7:0]  bus_write_data,
	input  logic        transfer_busy,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	output int          fail_count,
	output int          pending
);

	localparam int RAM_WORDS = 1 << 19;

	logic [1:0]  size_sel;
	logic [7:0]  status_r, command_r, imask_r, actl_r;
	logic [15:0] host_base, length_r, host_cur;
	logic [23:0] exp_base, exp_cur;
	logic [16:0] remaining;
	logic [1:0]  phase;
	logic [7:0]  ram [0:RAM_WORDS-1];
	rdx_pkg::result_t expected_results[$];

	initial begin
		size_sel  = 2'd0;
		status_r  = 8'h40;
		command_r = 8'h00;
		imask_r   = 8'h00;
		actl_r    = 8'h00;
		host_base = 16'h0;
		length_r  = 16'h0;
		host_cur  = 16'h0;
		exp_base  = 24'h0;
		exp_cur   = 24'h0;
		remaining = 17'h0;
		phase     = rdx_pkg::PH_IDLE;
		fail_count = 0;
		pending    = 0;
		for (int i = 0; i < RAM_WORDS; i++)
			ram[i] = 8'h00;
	end

	function automatic logic [18:0] ram_addr();
		logic [18:0] mask;
		mask = (size_sel == 2'd0) ? 19'h1FFFF : ((size_sel == 2'd1) ? 19'h3FFFF : 19'h7FFFF);
		return exp_cur[18:0] & mask;
	endfunction

	// byte that a compare step would match at the current expansion address
	function automatic logic [7:0] compare_byte();
		return ram[ram_addr()];
	endfunction

	task automatic issue_request(inout rdx_pkg::result_t r);
		r.bus_address = host_cur;
		if (command_r[1:0] == rdx_pkg::MODE_TO_HOST) begin
			r.kind = rdx_pkg::KIND_HWR;
			r.bus_write_data = ram[ram_addr()];
			phase = rdx_pkg::PH_WRITE;
		end else begin
			r.kind = rdx_pkg::KIND_HRD;
			phase = rdx_pkg::PH_READ;
		end
		r.busy = 1'b1;
	endtask

	task automatic finish_transfer(inout rdx_pkg::result_t r);
		if (!command_r[5]) begin
			host_base = host_cur;
			exp_base  = exp_cur;
			length_r  = remaining[15:0];
		end
		status_r  = status_r | 8'h40;
		command_r = command_r & 8'h7F;
		phase = rdx_pkg::PH_IDLE;
		r.kind = rdx_pkg::KIND_NONE;
		r.busy = 1'b0;
	endtask

	task automatic advance_transfer(inout rdx_pkg::result_t r);
		remaining = remaining - 17'd1;
		if (!actl_r[7])
			host_cur = host_cur + 16'd1;
		if (!actl_r[6])
			exp_cur = exp_cur + 24'd1;
		if (remaining == 17'd0)
			finish_transfer(r);
		else
			issue_request(r);
	endtask

	task automatic start_transfer(inout rdx_pkg::result_t r);
		host_cur  = host_base;
		exp_cur   = exp_base;
		remaining = (length_r != 16'd0) ? {1'b0, length_r} : 17'h10000;
		issue_request(r);
	endtask

	function automatic logic [7:0] reg_value(input logic [3:0] idx);
		logic [7:0] v;
		case (idx)
			rdx_pkg::REG_STATUS: begin
				v = status_r;
				status_r = status_r & 8'h1F;
			end
			rdx_pkg::REG_CMD:   v = command_r;
			rdx_pkg::REG_HLO:   v = host_base[7:0];
			rdx_pkg::REG_HHI:   v = host_base[15:8];
			rdx_pkg::REG_E0:    v = exp_base[7:0];
			rdx_pkg::REG_E1:    v = exp_base[15:8];
			rdx_pkg::REG_E2:    v = exp_base[23:16] | 8'hF8;
			rdx_pkg::REG_LLO:   v = length_r[7:0];
			rdx_pkg::REG_LHI:   v = length_r[15:8];
			rdx_pkg::REG_IMASK: v = imask_r | 8'h1F;
			rdx_pkg::REG_ACTL:  v = actl_r | 8'h3F;
			default:   v = 8'hFF;
		endcase
		return v;
	endfunction

	task automatic reg_store(input logic [3:0] idx, input logic [7:0] b,
			inout rdx_pkg::result_t r);
		case (idx)
			rdx_pkg::REG_CMD: begin
				command_r = b;
				if ((b & 8'h90) == 8'h90)
					start_transfer(r);
			end
			rdx_pkg::REG_HLO:   host_base[7:0]   = b;
			rdx_pkg::REG_HHI:   host_base[15:8]  = b;
			rdx_pkg::REG_E0:    exp_base[7:0]    = b;
			rdx_pkg::REG_E1:    exp_base[15:8]   = b;
			rdx_pkg::REG_E2:    exp_base[23:16]  = b;
			rdx_pkg::REG_LLO:   length_r[7:0]    = b;
			rdx_pkg::REG_LHI:   length_r[15:8]   = b;
			rdx_pkg::REG_IMASK: imask_r = b;
			rdx_pkg::REG_ACTL:  actl_r  = b;
			default: ;
		endcase
	endtask

	task automatic dma_step(input logic [1:0] op, input logic [3:0] idx, input logic [7:0] wd,
			input logic [7:0] bd, output rdx_pkg::result_t r);
		logic        busy;
		logic [18:0] a;
		busy = (phase != rdx_pkg::PH_IDLE);
		r = '0;
		r.busy = busy;
		if (op == rdx_pkg::CMD_READ) begin
			r.kind = rdx_pkg::KIND_REG;
			r.read_data = reg_value(idx);
		end else if (op == rdx_pkg::CMD_WRITE) begin
			if (!busy)
				reg_store(idx, wd, r);
		end else if (op == rdx_pkg::CMD_TRIG) begin
			if (!busy && (command_r & 8'h90) == 8'h80)
				start_transfer(r);
		end else if (busy) begin
			a = ram_addr();
			if (phase == rdx_pkg::PH_WRITE) begin
				advance_transfer(r);
			end else if (command_r[1:0] == rdx_pkg::MODE_TO_RAM) begin
				ram[a] = bd;
				advance_transfer(r);
			end else if (command_r[1:0] == rdx_pkg::MODE_SWAP) begin
				r.kind = rdx_pkg::KIND_HWR;
				r.bus_address = host_cur;
				r.bus_write_data = ram[a];
				r.busy = 1'b1;
				ram[a] = bd;
				phase = rdx_pkg::PH_WRITE;
			end else if (ram[a] != bd) begin
				status_r = status_r | 8'h20;
				finish_transfer(r);
			end else begin
				advance_transfer(r);
			end
		end
	endtask

	always @(posedge clk) begin
		rdx_pkg::result_t r;
		if (cfg_we) begin
			size_sel = cfg_wdata;
			if (size_sel != 2'd0)
				status_r = status_r | 8'h10;
			else
				status_r = status_r & 8'hEF;
		end
		if (push && !full) begin
			dma_step(command, reg_index, write_data, bus_data, r);
			expected_results.push_back(r);
		end
		if (pop && !empty) begin
			if (expected_results.size() == 0) begin
				$error("result with no transaction waiting: kind %0d", kind);
				fail_count++;
			end else begin
				r = expected_results.pop_front();
				if (kind !== r.kind) begin
					$error("kind: expected %0d, got %0d", r.kind, kind);
					fail_count++;
				end
				if (read_data !== r.read_data) begin
					$error("read_data: expected %h, got %h", r.read_data, read_data);
					fail_count++;
				end
				if (bus_address !== r.bus_address) begin
					$error("bus_address: expected %h, got %h", r.bus_address, bus_address);
					fail_count++;
				end
				if (bus_write_data !== r.bus_write_data) begin
					$error("bus_write_data: expected %h, got %h", r.bus_write_data,
						bus_write_data);
					fail_count++;
				end
				if (transfer_busy !== r.busy) begin
					$error("transfer_busy: expected %0d, got %0d", r.busy, transfer_busy);
					fail_count++;
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

// File: sim/dma_ram_expansion_controller_unit_tb.sv
// Testbench top for the DMA expansion RAM controller: clock, reset, stimulus and verdict.
// Depends on rdx_pkg, the block and dma_ram_expansion_controller_unit_chk.
`timescale 1ns / 100ps
module dma_ram_expansion_controller_unit_tb;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  command;
	logic [3:0]  reg_index;
	logic [7:0]  write_data;
	logic [7:0]  bus_data;
	logic        empty;
	logic        pop;
	logic [1:0]  kind;
	logic [7:0]  read_data;
	logic [15:0] bus_address;
	logic [7:0]  bus_write_data;
	logic        transfer_busy;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;
	int          fail_count;
	int          pending;
	int          cycles;
	int          sent;
	logic        steady;

	dma_ram_expansion_controller_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .command(command),
		.reg_index(reg_index), .write_data(write_data), .bus_data(bus_data), .empty(empty),
		.pop(pop), .kind(kind), .read_data(read_data), .bus_address(bus_address),
		.bus_write_data(bus_write_data), .transfer_busy(transfer_busy), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	dma_ram_expansion_controller_unit_chk chk (
		.clk(clk), .push(push), .full(full), .command(command), .reg_index(reg_index),
		.write_data(write_data), .bus_data(bus_data), .empty(empty), .pop(pop), .kind(kind),
		.read_data(read_data), .bus_address(bus_address), .bus_write_data(bus_write_data),
		.transfer_busy(transfer_busy), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("dma_ram_expansion_controller_unit test failed");
			$finish;
		end
	end

	always @(negedge clk)
		pop <= steady || ($urandom_range(0, 99) >= 16);

	// hold the transaction until it is taken; pushes stay high across back-to-back items
	task automatic send(input logic [1:0] op, input logic [3:0] idx, input logic [7:0] wd,
			input logic [7:0] bd);
		int gap;
		gap = (!steady && $urandom_range(0, 99) < 16) ? $urandom_range(1, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		command <= op;
		reg_index <= idx;
		write_data <= wd;
		bus_data <= bd;
		do
			@(posedge clk);
		while (full);
		sent++;
	endtask

	task automatic set_size(input logic [1:0] sel);
		@(negedge clk);
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= sel;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_transfer();
		logic [1:0] mode;
		logic [7:0] cmd_byte;
		int         len;
		int         steps;
		logic [7:0] bd;
		mode = 2'($urandom_range(0, 3));
		len = $urandom_range(1, 6);
		send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_HLO, 8'($urandom), 8'h00);
		send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_HHI,
			($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom), 8'h00);
		send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_E0, 8'($urandom), 8'h00);
		send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_E1, 8'($urandom), 8'h00);
		send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_E2, 8'($urandom), 8'h00);
		send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_LLO, 8'(len), 8'h00);
		send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_LHI, 8'h00, 8'h00);
		send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_ACTL, 8'($urandom), 8'h00);
		if ($urandom_range(0, 3) == 0)
			send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_IMASK, 8'($urandom), 8'h00);
		cmd_byte = {1'b1, 1'b0, $urandom_range(0, 1) == 1'b1, 1'b0, 2'($urandom), mode};
		cmd_byte[6] = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 1)) begin
			cmd_byte[4] = 1'b1;
			send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_CMD, cmd_byte, 8'h00);
		end else begin
			send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_CMD, cmd_byte, 8'h00);
			send(rdx_pkg::CMD_TRIG, 4'($urandom), 8'($urandom), 8'($urandom));
		end
		steps = (mode == rdx_pkg::MODE_SWAP) ? 2 * len : len;
		for (int i = 0; i < steps; i++) begin
			if ($urandom_range(0, 9) == 0)
				send(rdx_pkg::CMD_READ, 4'($urandom), 8'($urandom), 8'($urandom));
			if ($urandom_range(0, 19) == 0)
				send(rdx_pkg::CMD_WRITE, 4'($urandom), 8'($urandom), 8'($urandom));
			bd = 8'($urandom);
			// compare mostly matches so that it runs the whole length;
			// let the checker take the last transaction first
			#1;
			if (mode == rdx_pkg::MODE_COMPARE && $urandom_range(0, 9) != 0)
				bd = chk.compare_byte();
			send(rdx_pkg::CMD_DONE, 4'($urandom), 8'($urandom), bd);
		end
		send(rdx_pkg::CMD_READ, rdx_pkg::REG_STATUS, 8'($urandom), 8'($urandom));
	endtask

	task automatic run_phase(input int quota);
		logic [7:0] wd;
		int         stop;
		stop = sent + quota;
		while (sent < stop) begin
			if ($urandom_range(0, 3) != 0) begin
				run_transfer();
			end else begin
				wd = 8'($urandom);
				// keep noise from arming a transfer of unknown length
				wd[7] = 1'b0;
				send(2'($urandom), 4'($urandom), wd, 8'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		command = rdx_pkg::CMD_READ;
		reg_index = 4'd0;
		write_data = 8'h00;
		bus_data = 8'h00;
		cfg_we = 1'b0;
		cfg_wdata = 2'd0;
		cycles = 0;
		sent = 0;
		steady = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < 16; i++)
			send(rdx_pkg::CMD_READ, 4'(i), 8'h00, 8'h00);
		send(rdx_pkg::CMD_WRITE, 4'd12, 8'hFF, 8'hFF);
		send(rdx_pkg::CMD_DONE, 4'd0, 8'h00, 8'hFF);
		send(rdx_pkg::CMD_TRIG, 4'd0, 8'h00, 8'h00);
		send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_E2, 8'hFF, 8'h00);
		send(rdx_pkg::CMD_READ, rdx_pkg::REG_E2, 8'h00, 8'h00);
		// zero length compare that mismatches on its first byte
		send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_LLO, 8'h00, 8'h00);
		send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_CMD, 8'h93, 8'h00);
		send(rdx_pkg::CMD_WRITE, rdx_pkg::REG_HLO, 8'h55, 8'h00);
		send(rdx_pkg::CMD_DONE, 4'd0, 8'h00, 8'hA5);
		send(rdx_pkg::CMD_READ, rdx_pkg::REG_STATUS, 8'h00, 8'h00);

		set_size(2'd2);
		run_phase(300);
		set_size(2'd1);
		steady = 1'b1;
		run_phase(300);
		steady = 1'b0;
		set_size(2'd3);
		run_phase(300);
		set_size(2'd0);
		run_phase(300);
		set_size(2'd2);
		run_phase(300);
		set_size(2'd0);
		run_phase(250);

		@(negedge clk);
		push <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("dma_ram_expansion_controller_unit test passed");
		else
			$display("dma_ram_expansion_controller_unit test failed");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/rdx_pkg.sv
hw/rtl/rdx_fifo.sv
hw/rtl/rdx_front.sv
hw/rtl/rdx_back.sv
hw/rtl/dma_ram_expansion_controller_unit.sv
hw/rtl/rdx_checker.sv
sim/dma_ram_expansion_controller_unit_chk.sv
sim/dma_ram_expansion_controller_unit_tb.sv
